// File: src/itt_pkg.sv
// Shared types and constants for the IOVA translation table.
`default_nettype none

package itt_pkg;

   localparam int ENTRIES     = 64;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PAGE_SHIFT  = 12;
   localparam int FUNC_W      = 2;
   localparam int IOVA_W      = 48;
   localparam int PADDR_W     = 52;
   localparam int SIZE_W      = 32;
   localparam int STATUS_W    = 3;
   localparam int UNMAP_W     = 13;
   localparam int IOVA_PAGE_W = IOVA_W - PAGE_SHIFT;
   localparam int PHYS_PAGE_W = PADDR_W - PAGE_SHIFT;

   localparam logic [SIZE_W-1:0]  PAGE_BYTES   = SIZE_W'(64'd1 << PAGE_SHIFT);
   localparam logic [UNMAP_W-1:0] UNMAP_BYTES  = UNMAP_W'(64'd1 << PAGE_SHIFT);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_MAP    = 2'd0,
      FUNC_UNMAP  = 2'd1,
      FUNC_LOOKUP = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_INVALID = 3'd1,
      ST_EXISTS  = 3'd2,
      ST_MISSING = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [IOVA_W-1:0]  iova;
      logic [PADDR_W-1:0] paddr;
      logic [SIZE_W-1:0]  size_bytes;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [PADDR_W-1:0] phys_addr;
      logic [UNMAP_W-1:0] unmapped_bytes;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/iova_translation_table_unit.sv
// Top level of the IOVA translation table: a fully associative 4 KB page map.
//
// Usage: a request word (map, unmap or lookup) is taken at a rising edge where
// start is high and busy is low. busy is never raised, so one word can be
// issued every cycle. Each request yields exactly one response word, shown on
// rsp_data for a single cycle with rsp_strobe high, after the request and
// response registers. Responses come back in request order.
//
// Timing: the request is registered, then in the next cycle all tags are
// compared in parallel, the first free slot is chosen, the valid bits and
// tags are updated and the status is registered. The physical page store is
// a memory read at the hit slot in that same cycle with registered output.
// A request therefore sees every table change made by the one before it.
// Throughput is one word per cycle.
//
// Reset clears all valid bits at once, so the table is empty right after
// reset and no clearing pass is needed. The receiver cannot stall: a
// response word must be taken in the cycle it is shown.
`default_nettype none

module iova_translation_table_unit (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire itt_pkg::req_type req_data,
   output logic                 rsp_strobe,
   output itt_pkg::rsp_type     rsp_data
);

   // Request register.
   logic             req_vld_ff;
   itt_pkg::req_type req_ff;

   // Table state.
   logic [itt_pkg::ENTRIES-1:0]     valid_ff, valid_in;
   logic [itt_pkg::IOVA_PAGE_W-1:0] tag_ff [itt_pkg::ENTRIES];
   logic [itt_pkg::PHYS_PAGE_W-1:0] phys_mem [itt_pkg::ENTRIES];
   logic [itt_pkg::PHYS_PAGE_W-1:0] phys_rd_ff;

   // Response register.
   logic                        rsp_vld_ff;
   itt_pkg::status_type         status_ff, status_in;
   logic [itt_pkg::UNMAP_W-1:0] unmap_ff, unmap_in;
   logic                        hit_out_ff, hit_out_in;

   logic [itt_pkg::IOVA_PAGE_W-1:0] page;
   logic                            aligned;
   logic                            size_ok;
   logic                            paddr_aligned;
   logic [itt_pkg::ENTRIES-1:0]     match;
   logic                            hit;
   logic                            has_free;
   logic [itt_pkg::IDX_W-1:0]       hit_idx;
   logic [itt_pkg::IDX_W-1:0]       free_idx;
   logic                            map_wr;
   logic                            unmap_wr;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start && !busy;
      end
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   assign page          = req_ff.iova[itt_pkg::IOVA_W-1:itt_pkg::PAGE_SHIFT];
   assign aligned       = (req_ff.iova[itt_pkg::PAGE_SHIFT-1:0] == '0);
   assign paddr_aligned = (req_ff.paddr[itt_pkg::PAGE_SHIFT-1:0] == '0);
   assign size_ok       = (req_ff.size_bytes == itt_pkg::PAGE_BYTES);

   // Parallel tag compare; at most one slot can match since a page is never
   // stored twice.
   always_comb begin
      for (int i = 0; i < itt_pkg::ENTRIES; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == page);
      end
   end

   assign hit      = |match;
   assign has_free = ~&valid_ff;

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < itt_pkg::ENTRIES; i++) begin
         if (match[i]) begin
            hit_idx = hit_idx | itt_pkg::IDX_W'(i);
         end
      end
   end

   // Lowest-numbered free slot.
   always_comb begin
      free_idx = '0;
      for (int i = itt_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = itt_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      status_in  = itt_pkg::ST_INVALID;
      unmap_in   = '0;
      hit_out_in = 1'b0;
      map_wr     = 1'b0;
      unmap_wr   = 1'b0;
      unique case (req_ff.func)
         itt_pkg::FUNC_MAP: begin
            if (!size_ok || !aligned || !paddr_aligned) begin
               status_in = itt_pkg::ST_INVALID;
            end else if (hit) begin
               status_in = itt_pkg::ST_EXISTS;
            end else if (!has_free) begin
               status_in = itt_pkg::ST_FULL;
            end else begin
               status_in = itt_pkg::ST_OK;
               map_wr    = req_vld_ff;
            end
         end
         itt_pkg::FUNC_UNMAP: begin
            if (!size_ok) begin
               status_in = itt_pkg::ST_INVALID;
            end else if (!(aligned && hit)) begin
               status_in = itt_pkg::ST_MISSING;
            end else begin
               status_in = itt_pkg::ST_OK;
               unmap_in  = itt_pkg::UNMAP_BYTES;
               unmap_wr  = req_vld_ff;
            end
         end
         itt_pkg::FUNC_LOOKUP: begin
            if (aligned && hit) begin
               status_in  = itt_pkg::ST_OK;
               hit_out_in = 1'b1;
            end else begin
               status_in = itt_pkg::ST_MISSING;
            end
         end
         default: begin
            status_in = itt_pkg::ST_INVALID;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (map_wr) begin
         valid_in[free_idx] = 1'b1;
      end
      if (unmap_wr) begin
         valid_in[hit_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         rsp_vld_ff <= req_vld_ff;
      end
      status_ff  <= status_in;
      unmap_ff   <= unmap_in;
      hit_out_ff <= hit_out_in;
      if (map_wr) begin
         tag_ff[free_idx] <= page;
      end
   end

   // Physical page memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (map_wr) begin
         phys_mem[free_idx] <= req_ff.paddr[itt_pkg::PADDR_W-1:itt_pkg::PAGE_SHIFT];
      end
      phys_rd_ff <= phys_mem[hit_idx];
   end

   assign rsp_strobe              = rsp_vld_ff;
   assign rsp_data.status         = status_ff;
   assign rsp_data.unmapped_bytes = unmap_ff;
   assign rsp_data.phys_addr      = hit_out_ff ?
                                    {phys_rd_ff, {itt_pkg::PAGE_SHIFT{1'b0}}} : '0;

   // A page is never held in two slots.
   a_match_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("more than one slot matches the same page");

   // Every accepted request word gets its response after the request and response registers.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("response missing for an accepted request");

   // A successful map fills exactly one slot.
   a_map_fills: assert property (@(posedge clock) disable iff (reset)
      map_wr |=> ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("map did not fill exactly one slot");

   // A successful unmap frees exactly one slot.
   a_unmap_frees: assert property (@(posedge clock) disable iff (reset)
      unmap_wr |=> ($countones(valid_ff) + 1 == $past($countones(valid_ff))))
      else $error("unmap did not free exactly one slot");

endmodule

`default_nettype wire
